// ===== sv/scpl_pkg.sv =====
// Shared constants and command types for the sector cache partition lookup block.
package scpl_pkg;

  // Number of open-sector table slots.
  localparam int unsigned SlotCount = 4;
  // Number of partition entries.
  localparam int unsigned PartCount = 4;

  localparam int unsigned LbaW      = 33;
  localparam int unsigned RegW      = 32;
  localparam int unsigned PartIdxW  = 2;
  localparam int unsigned SlotOutW  = 2;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned SlotIdxW  = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int unsigned FillW     = $clog2(SlotCount + 1);

  // Packed beat widths, rounded up to whole bytes.
  localparam int unsigned InTdataW  = ((LbaW + 7) / 8) * 8;
  localparam int unsigned OutFieldW = 1 + 1 + SlotOutW + PartIdxW + RegW + 1 + LbaW;
  localparam int unsigned OutTdataW = ((OutFieldW + 7) / 8) * 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming address
    logic commit;  // update the table and register the result
  } scpl_cmd_t;

endpackage

// ===== sv/scpl_ctrl.sv =====
// Controller state machine: sequences capture, lookup and result hand-off.
module scpl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output scpl_pkg::scpl_cmd_t cmd_o
);
  import scpl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CALC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   room;

  assign room = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.commit = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CALC;
        end
      end
      S_CALC: begin
        if (room) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;

endmodule

// ===== sv/scpl_dp.sv =====
// Datapath: partition registers, open-sector table, compares and result register.
module scpl_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [scpl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [scpl_pkg::RegW-1:0]      cfg_data_i,
  input  logic [scpl_pkg::InTdataW-1:0]  in_data_i,
  input  scpl_pkg::scpl_cmd_t            cmd_i,
  output logic [scpl_pkg::OutTdataW-1:0] out_data_o
);
  import scpl_pkg::*;

  logic [RegW-1:0]     part_start_q [PartCount];
  logic [RegW-1:0]     part_size_q  [PartCount];

  logic [LbaW-1:0]     slot_addr_q  [SlotCount];
  logic [PartIdxW-1:0] slot_part_q  [SlotCount];
  logic [SlotCount-1:0] slot_valid_q;
  logic [SlotIdxW-1:0] oldest_q;
  logic [FillW-1:0]    fill_q;

  logic [LbaW-1:0]     lba_q;
  logic [OutTdataW-1:0] out_q;

  // Configuration writes: low index bit picks start or size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PartCount; p++) begin
        part_start_q[p] <= '0;
        part_size_q[p]  <= '0;
      end
    end else if (cfg_we_i) begin
      for (int p = 0; p < PartCount; p++) begin
        if (cfg_idx_i[CfgIdxW-1:1] == (CfgIdxW-1)'(p)) begin
          if (cfg_idx_i[0]) begin
            part_size_q[p]  <= cfg_data_i;
          end else begin
            part_start_q[p] <= cfg_data_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lba_q <= in_data_i[LbaW-1:0];
    end
  end

  // Tag compare over all slots, lowest slot wins.
  logic                hit;
  logic [SlotIdxW-1:0] hit_idx;
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (slot_valid_q[i] && (slot_addr_q[i] == lba_q)) begin
        hit     = 1'b1;
        hit_idx = SlotIdxW'(i);
      end
    end
  end

  // Range compare over all partitions, lowest entry wins; empty entries never match.
  logic                match;
  logic [PartIdxW-1:0] match_idx;
  logic [LbaW:0]       range_end;
  always_comb begin
    match     = 1'b0;
    match_idx = '0;
    range_end = '0;
    for (int p = PartCount - 1; p >= 0; p--) begin
      range_end = (LbaW+1)'(part_start_q[p]) + (LbaW+1)'(part_size_q[p]);
      if ((part_size_q[p] != '0) && (lba_q >= LbaW'(part_start_q[p])) &&
          ((LbaW+1)'(lba_q) < range_end)) begin
        match     = 1'b1;
        match_idx = PartIdxW'(p);
      end
    end
  end

  // Insertion slot: next free slot after the oldest, or the oldest when full.
  logic                full;
  logic [FillW:0]      ins_sum;
  logic [SlotIdxW-1:0] ins_idx;
  logic [SlotIdxW-1:0] oldest_next;
  logic                insert;
  assign full    = (fill_q == FillW'(SlotCount));
  assign ins_sum = (FillW+1)'(oldest_q) + (FillW+1)'(fill_q);
  always_comb begin
    if (full) begin
      ins_idx = oldest_q;
    end else if (ins_sum >= (FillW+1)'(SlotCount)) begin
      ins_idx = SlotIdxW'(ins_sum - (FillW+1)'(SlotCount));
    end else begin
      ins_idx = SlotIdxW'(ins_sum);
    end
  end
  assign oldest_next = (oldest_q == SlotIdxW'(SlotCount - 1)) ? '0 : oldest_q + 1'b1;
  assign insert      = cmd_i.commit && !hit && match;

  // Result fields.
  logic [PartIdxW-1:0] pidx;
  logic [RegW-1:0]     rel;
  logic [SlotIdxW-1:0] res_slot;
  logic                err;
  logic                ev;
  logic [LbaW-1:0]     ev_lba;
  assign pidx     = hit ? slot_part_q[hit_idx] : match_idx;
  assign rel      = RegW'(lba_q - LbaW'(part_start_q[pidx]));
  assign res_slot = hit ? hit_idx : ins_idx;
  assign err      = !hit && !match;
  assign ev       = !hit && match && full;
  assign ev_lba   = ev ? slot_addr_q[oldest_q] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      oldest_q     <= '0;
      fill_q       <= '0;
    end else if (insert) begin
      slot_valid_q[ins_idx] <= 1'b1;
      if (full) begin
        oldest_q <= oldest_next;
      end else begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (insert) begin
      slot_addr_q[ins_idx] <= lba_q;
      slot_part_q[ins_idx] <= match_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (err) begin
        out_q <= OutTdataW'({LbaW'(0), 1'b0, RegW'(0), PartIdxW'(0),
                             SlotOutW'(0), 1'b1, 1'b0});
      end else begin
        out_q <= OutTdataW'({ev_lba, ev, rel, pidx, SlotOutW'(res_slot), 1'b0, hit});
      end
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== sv/sector_cache_partition_lookup_core.sv =====
// Top level of the sector cache partition lookup block.
// Each request beat carries an absolute sector address. The block first looks it
// up in a four-slot table of open sectors; on a hit it returns the holding slot,
// the slot's partition and the address relative to that partition's current start.
// On a miss it takes the first of the four partition entries whose range holds the
// address (entries of size zero never match), enters the address into the table in
// FIFO order and, when the table is full, drops the oldest entry and reports its
// address. If no partition holds the address, the error flag is set, every other
// field is zero and the table is left as it was. The controller takes the beat,
// then commits the lookup into the result register; a stalled result register
// holds the commit back. A new request beat is taken as soon as the previous
// result sits in that register, so a waiting result does not hold up the next
// lookup's address capture. The user must write partition registers through the
// plain write port only while no request is in flight; this is not enforced.
module sector_cache_partition_lookup_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port: index 2n is the start, 2n+1 the size of entry n.
  input  logic                           cfg_we_i,
  input  logic [scpl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [scpl_pkg::RegW-1:0]      cfg_data_i,
  // Request stream.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [scpl_pkg::InTdataW-1:0]  s_axis_tdata_i,  // lba[32:0], zero padding above
  // Result stream.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // From bit 0: hit, error, slot[1:0], partition_index[1:0], sector_offset[31:0],
  // evicted, evicted_lba[32:0].
  output logic [scpl_pkg::OutTdataW-1:0] m_axis_tdata_o
);
  import scpl_pkg::*;

  scpl_cmd_t cmd;

  // The controller sequences the request; the datapath holds all storage.
  scpl_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cmd_o           (cmd)
  );

  scpl_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata_i),
    .cmd_i      (cmd),
    .out_data_o (m_axis_tdata_o)
  );

  // A hit and an error can never be reported together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("hit and error flagged on the same result");

  // An eviction only happens on a successful miss.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[38]) |-> (!m_axis_tdata_o[0] && !m_axis_tdata_o[1]))
    else $error("eviction reported on a hit or an error");

  // After a request beat is taken, the block takes no further beat until it commits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request taken while a lookup is still pending");

  // A commit always leaves a valid result behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> m_axis_tvalid_o)
    else $error("committed result not presented");

endmodule

// ===== tb/sector_cache_partition_lookup_core_tb.sv =====
// Self-checking testbench for the sector cache partition lookup block.
module sector_cache_partition_lookup_core_tb ();

  timeunit 1ns;
  timeprecision 1ps;

  import scpl_pkg::*;

  // Cycle budget for the whole run: even with the receiver stalling most of the
  // time, it is several times the slowest correct run.
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned ItemsPerRun  = 277;
  localparam int unsigned LongHoldOff  = 150;
  localparam int unsigned RecentDepth  = 6;
  localparam int unsigned TailCycles   = 8;

  // Register map of the configuration port: a start and a size per partition entry.
  typedef enum logic [CfgIdxW-1:0] {
    RegP0Start, RegP0Size, RegP1Start, RegP1Size,
    RegP2Start, RegP2Size, RegP3Start, RegP3Size
  } cfg_reg_e;

  // One result beat. The last member sits in the lowest bits, so a cast of the
  // packed beat lines the fields up with the port layout.
  typedef struct packed {
    logic [LbaW-1:0]     evicted_lba;
    logic                evicted;
    logic [RegW-1:0]     sector_offset;
    logic [PartIdxW-1:0] partition_index;
    logic [SlotOutW-1:0] slot;
    logic                error;
    logic                hit;
  } lookup_result_t;

  // The scoreboard keeps its own copy of the partition table and of the
  // open-sector table. Each accepted request is looked up here and the outcome
  // queued; each result beat is compared with the oldest queued outcome.
  class lookup_scoreboard;
    logic [RegW-1:0]     part_start [PartCount];
    logic [RegW-1:0]     part_size  [PartCount];
    logic [LbaW-1:0]     slot_lba   [SlotCount];
    logic [PartIdxW-1:0] slot_part  [SlotCount];
    bit                  slot_valid [SlotCount];
    int unsigned         oldest;
    int unsigned         fill;
    lookup_result_t      expected_q [$];
    int unsigned         fail_count;
    int unsigned         request_count;
    int unsigned         hit_count;
    int unsigned         error_count;
    int unsigned         evict_count;

    function void reset_state();
      foreach (part_start[i]) begin
        part_start[i] = '0;
        part_size[i]  = '0;
      end
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      oldest = 0;
      fill   = 0;
    endfunction

    function void apply_write(cfg_reg_e idx, logic [RegW-1:0] value);
      case (idx)
        RegP0Start: part_start[0] = value;
        RegP0Size:  part_size[0]  = value;
        RegP1Start: part_start[1] = value;
        RegP1Size:  part_size[1]  = value;
        RegP2Start: part_start[2] = value;
        RegP2Size:  part_size[2]  = value;
        RegP3Start: part_start[3] = value;
        RegP3Size:  part_size[3]  = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Looks the address up in the open-sector table and, on a miss, in the
    // partition entries, updating the table as the block should.
    function void note_request(logic [LbaW-1:0] lba);
      lookup_result_t r;
      bit             matched;
      int unsigned    p;
      int unsigned    s;
      r = '0;
      matched = 1'b0;
      p = 0;
      request_count++;
      for (int i = 0; i < SlotCount; i++) begin
        if (!r.hit && slot_valid[i] && slot_lba[i] == lba) begin
          r.hit             = 1'b1;
          r.slot            = SlotOutW'(i);
          r.partition_index = slot_part[i];
          // The start register may have changed since the sector was entered.
          r.sector_offset   = lba[RegW-1:0] - part_start[slot_part[i]];
        end
      end
      if (r.hit) begin
        hit_count++;
      end else begin
        for (int i = 0; i < PartCount; i++) begin
          if (!matched && part_size[i] != '0 &&
              {2'b00, lba} >= {3'b000, part_start[i]} &&
              {2'b00, lba} < ({3'b000, part_start[i]} + {3'b000, part_size[i]})) begin
            matched = 1'b1;
            p = i;
          end
        end
        if (!matched) begin
          // Nothing holds the address: error only, the table stays as it is.
          r.error = 1'b1;
          error_count++;
        end else begin
          if (fill < SlotCount) begin
            s = (oldest + fill) % SlotCount;
            fill++;
          end else begin
            s = oldest;
            r.evicted     = 1'b1;
            r.evicted_lba = slot_lba[s];
            oldest        = (oldest + 1) % SlotCount;
            evict_count++;
          end
          slot_lba[s]       = lba;
          slot_part[s]      = PartIdxW'(p);
          slot_valid[s]     = 1'b1;
          r.slot            = SlotOutW'(s);
          r.partition_index = PartIdxW'(p);
          r.sector_offset   = lba[RegW-1:0] - part_start[p];
        end
      end
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [LbaW-1:0] want, logic [LbaW-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(logic [OutTdataW-1:0] beat);
      lookup_result_t got;
      lookup_result_t want;
      got = lookup_result_t'(beat[OutFieldW-1:0]);
      if (expected_q.size() == 0) begin
        $error("result beat %0h arrived with no request outstanding", beat);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        compare_field("hit", want.hit, got.hit);
        compare_field("error", want.error, got.error);
        compare_field("slot", want.slot, got.slot);
        compare_field("partition_index", want.partition_index, got.partition_index);
        compare_field("sector_offset", want.sector_offset, got.sector_offset);
        compare_field("evicted", want.evicted, got.evicted);
        compare_field("evicted_lba", want.evicted_lba, got.evicted_lba);
      end
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i       = '0;
  logic [RegW-1:0]      cfg_data_i      = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i  = '0;  // lba[32:0], zero padding above
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // From bit 0: hit, error, slot[1:0], partition_index[1:0], sector_offset[31:0],
  // evicted, evicted_lba[32:0].
  logic [OutTdataW-1:0] m_axis_tdata_o;

  lookup_scoreboard     sb;
  logic [LbaW-1:0]      recent_lba [$];
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_idle_pct = 0;
  int unsigned          phase_num     = 0;
  int unsigned          rx_hold_left  = 0;
  bit                   rx_hold_done  = 1'b0;
  int unsigned          cycle_count   = 0;

  sector_cache_partition_lookup_core dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  always #6 clk_i = ~clk_i;

  // Result side. Each accepted beat is checked at the edge that takes it; the
  // values seen here are those from before the edge, so the order of processes
  // within the step does not matter. Once in the last phase the receiver holds
  // off for a long stretch while requests keep coming, so that the block backs
  // up all the way to its input.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o);
    end
    if (phase_num == 2 && !rx_hold_done && s_axis_tvalid_i) begin
      rx_hold_done = 1'b1;
      rx_hold_left = LongHoldOff;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("status: fail");
      $finish;
    end
  end

  // Writes one register; the enable is lowered by the caller after the last write.
  task automatic write_reg(cfg_reg_e idx, logic [RegW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.apply_write(idx, value);
  endtask

  // Loads all eight partition registers. Only called while nothing is in flight.
  task automatic program_layout(input logic [RegW-1:0] st [PartCount],
                                input logic [RegW-1:0] sz [PartCount]);
    write_reg(RegP0Start, st[0]);
    write_reg(RegP0Size,  sz[0]);
    write_reg(RegP1Start, st[1]);
    write_reg(RegP1Size,  sz[1]);
    write_reg(RegP2Start, st[2]);
    write_reg(RegP2Size,  sz[2]);
    write_reg(RegP3Start, st[3]);
    write_reg(RegP3Size,  sz[3]);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // A mix of empty, tiny, moderate and full-width entries at random places,
  // some of them near the top of the 32-bit start range so that ranges run
  // past 2^32.
  task automatic random_layout(output logic [RegW-1:0] st [PartCount],
                               output logic [RegW-1:0] sz [PartCount]);
    int unsigned pick;
    for (int i = 0; i < PartCount; i++) begin
      pick = $urandom_range(99);
      if (pick < 20)      st[i] = $urandom_range(255);
      else if (pick < 40) st[i] = 32'hFFFF_FFFF - $urandom_range(255);
      else                st[i] = $urandom;
      pick = $urandom_range(99);
      if (pick < 15)      sz[i] = '0;
      else if (pick < 55) sz[i] = $urandom_range(32, 1);
      else if (pick < 85) sz[i] = $urandom_range(4096, 1);
      else if (pick < 93) sz[i] = 32'hFFFF_FFFF;
      else                sz[i] = $urandom;
    end
  endtask

  // Withdraws the request line, then waits until every result is back and the
  // block has settled, so that the registers can be rewritten safely.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Offers one request beat and returns at the edge that takes it. The valid
  // line gets at most one assignment per time step.
  task automatic send_request(logic [LbaW-1:0] lba);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= InTdataW'(lba);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_request(lba);
    recent_lba.push_back(lba);
    if (recent_lba.size() > RecentDepth) void'(recent_lba.pop_front());
  endtask

  // Chooses a request address. Most addresses are recent ones (hits, or
  // re-entry after eviction) or fall inside a live partition; a share sits on
  // range edges, and the rest is noise across the whole 33-bit space.
  function automatic logic [LbaW-1:0] pick_lba();
    int unsigned     sel;
    int unsigned     p;
    logic [LbaW-1:0] base;
    logic [LbaW-1:0] span;
    sel  = $urandom_range(99);
    p    = $urandom_range(PartCount - 1);
    base = LbaW'(sb.part_start[p]);
    span = LbaW'(sb.part_size[p]);
    if (sel < 35 && recent_lba.size() != 0) begin
      return recent_lba[$urandom_range(recent_lba.size() - 1)];
    end
    if (sel < 75 && span != '0) begin
      return base + LbaW'($urandom % sb.part_size[p]);
    end
    if (sel < 90) begin
      case ($urandom_range(3))
        0:       return base - 1'b1;
        1:       return base;
        2:       return base + span - 1'b1;
        default: return base + span;
      endcase
    end
    return {1'($urandom_range(1)), 32'($urandom)};
  endfunction

  // Directed addresses for the first layout: entry 0 is empty, entries 1 and 2
  // overlap so the lower index must win, and entry 3 runs from the top start up to
  // 33'h1_FFFF_FFFD. The list walks through errors, a fill of the table, a
  // hit, evictions and the re-entry of an evicted sector.
  logic [LbaW-1:0] first_layout_lba [$] = '{
    33'd0, 33'd100, 33'd149, 33'd150, 33'd100, 33'h1_FFFF_FFFE, 33'h1_FFFF_FFFF,
    33'h0_FFFF_FFFF, 33'h0_FFFF_FFFE, 33'd1119, 33'd1120, 33'd100, 33'h1_FFFF_FFFE
  };
  // After the starts move: hits whose relative address is taken from the new
  // start (one of them wrapping below zero), then misses under the new layout.
  logic [LbaW-1:0] second_layout_lba [$] = '{
    33'd100, 33'h1_FFFF_FFFE, 33'h0_FFFF_FFFF, 33'd1119, 33'd5, 33'd0, 33'h1_0000_0000
  };

  initial begin
    logic [RegW-1:0] st [PartCount];
    logic [RegW-1:0] sz [PartCount];
    sb = new;
    sb.reset_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with the first idling pattern.
    send_idle_pct = 28;
    recv_idle_pct = 61;
    st = '{32'd100, 32'd100, 32'd120, 32'hFFFF_FFFF};
    sz = '{32'd0, 32'd50, 32'd1000, 32'hFFFF_FFFF};
    program_layout(st, sz);
    foreach (first_layout_lba[i]) send_request(first_layout_lba[i]);
    settle();
    st = '{32'd100, 32'h8000_0000, 32'd120, 32'd0};
    sz = '{32'd1, 32'd50, 32'd1000, 32'hFFFF_FFFF};
    program_layout(st, sz);
    foreach (second_layout_lba[i]) send_request(second_layout_lba[i]);

    // Random part in three phases. The middle one uses an extreme layout:
    // a full-width entry from zero shadowing a small one, another full-width
    // entry from the top start, and an empty one.
    for (int ph = 0; ph < 3; ph++) begin
      settle();
      phase_num = ph;
      case (ph)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 61;
          random_layout(st, sz);
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 28;
          st = '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678};
          sz = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1};
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          random_layout(st, sz);
        end
      endcase
      program_layout(st, sz);
      for (int n = 0; n < ItemsPerRun; n++) send_request(pick_lba());
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain: every result must come back, then a short quiet tail catches any
    // stray beat.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d requests over five partition layouts: %0d hits, %0d with no partition,",
             sb.request_count, sb.hit_count, sb.error_count);
    $display("%0d evictions, with stalls on both sides and one long result hold-off",
             sb.evict_count);
    if (sb.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
